[hw/rtl/azimuth_bin_nearest_ray_table_macros.svh]
// Assertion macros shared by the azimuth bin table RTL.
// Needs nothing else; included by files that carry concurrent checks.
`ifndef AZIMUTH_BIN_NEAREST_RAY_TABLE_MACROS_SVH
`define AZIMUTH_BIN_NEAREST_RAY_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ABNR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ABNR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/abnr_pkg.sv]
// Shared types, constants and helper functions of the azimuth bin table.
// No dependencies; imported by abnr_dist and the top level of the block.
`default_nettype none

package abnr_pkg;

  localparam int NUM_BINS  = 720;
  localparam int MAX_RAYS  = 1024;
  localparam int FRAC_BITS = 4;

  localparam int RAY_W   = 10;
  localparam int AZ_W    = 14;
  localparam int IDX_W   = 10;
  localparam int TOL_W   = 5;
  localparam int CMD_W   = 2;
  localparam int BIN_W   = $clog2(NUM_BINS);
  localparam int EPOCH_W = 4;

  localparam int CIRCLE    = NUM_BINS << FRAC_BITS;
  localparam int HALF_STEP = (1 << FRAC_BITS) >> 1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef logic [AZ_W-1:0]  az_t;
  typedef logic [BIN_W-1:0] bin_t;

  // one table entry; valid only when filled and tagged with the live epoch
  typedef struct packed {
    logic                filled;
    logic [EPOCH_W-1:0]  epoch;
    az_t                 az;
    logic [RAY_W-1:0]    ray;
  } bin_word_t;

  localparam int WORD_W = $bits(bin_word_t);

  typedef struct packed {
    logic vld;
    bin_t bin;
  } bin_probe_t;

  typedef struct packed {
    logic en;
    bin_t bin;
  } bin_wr_t;

  // azimuths arrive below twice the circle, so one subtract reduces them
  function automatic az_t az_reduce(input az_t az);
    az_t res;
    res = (az >= AZ_W'(CIRCLE)) ? az - AZ_W'(CIRCLE) : az;
    return res;
  endfunction

  function automatic az_t bin_centre(input bin_t bin);
    az_t res;
    res = AZ_W'(bin) << FRAC_BITS;
    return res;
  endfunction

  // shorter way round the circle; both operands already reduced
  function automatic az_t circ_dist(input az_t a, input az_t b);
    az_t d;
    az_t other;
    d     = (a >= b) ? a - b : b - a;
    other = AZ_W'(CIRCLE) - d;
    return (other < d) ? other : d;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/abnr_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// Standalone; holds the bin table of the azimuth bin table block.
`default_nettype none

module abnr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/abnr_dist.sv]
// Distance compare pipeline: takes a bin's read data, decides the write-back.
// Depends on abnr_pkg.
`default_nettype none

module abnr_dist
  import abnr_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire bin_probe_t     s1,
  input  wire bin_word_t      rd_word,
  input  wire az_t            new_az,
  input  wire [EPOCH_W-1:0]   epoch,
  output logic                busy,
  output bin_wr_t             wr
);

  logic  s2_v_r;
  bin_t  s2_bin_r;
  logic  s2_empty_r;
  az_t   s2_dn_r;
  az_t   s2_dh_r;

  az_t   centre;
  logic  held_ok;

  assign centre  = bin_centre(s1.bin);
  assign held_ok = rd_word.filled && (rd_word.epoch == epoch);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1.vld;
    end
    s2_bin_r   <= s1.bin;
    s2_empty_r <= !held_ok;
    s2_dn_r    <= circ_dist(centre, new_az);
    s2_dh_r    <= circ_dist(centre, rd_word.az);
  end

  // ties keep the held ray
  assign wr.en  = s2_v_r && (s2_empty_r || (s2_dn_r < s2_dh_r));
  assign wr.bin = s2_bin_r;
  assign busy   = s1.vld || s2_v_r;

endmodule

`default_nettype wire

[hw/rtl/azimuth_bin_nearest_ray_table.sv]
// Azimuth bin table, top level: command sequencer, table RAM, compare pipe.
// Depends on abnr_pkg, abnr_ram, abnr_dist and the assertion macros header.
//
// Usage: items enter on in_* (in_tuser = command, in_tdata = ray number,
// azimuth, bin index); every item yields exactly one item on out_*
// (out_tuser = bin valid, out_tdata = ray number, zero unless a read hits).
// Users write the tolerance register on cfg_* while the block is idle; unenforced.
// One item is worked on at a time. A read passes through ST_RD and ST_RDW;
// an unused code and a clear go straight to the result, but a clear sweeps
// the table first when the 4-bit epoch wraps; an add writes the centre bin,
// then reads the 2*tolerance neighbour bins, one table bin each cycle, with
// a two-stage compare before the write-back, and waits for the compare pipe
// to drain. The next item can be taken in the cycle after the result loads.
// The result sits in an output register, so in_tready returns while it
// waits; a stalled receiver holds off only the next result.
// After reset the table RAM is swept, one bin a cycle, over all 720 bins;
// in_tready stays low meanwhile, cfg writes are taken at any time.
`default_nettype none
`include "azimuth_bin_nearest_ray_table_macros.svh"

module azimuth_bin_nearest_ray_table
  import abnr_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  // [9:0] ray_number, [23:10] ray_azimuth, [33:24] bin_index, rest zero
  input  wire [IN_DATA_W-1:0]    in_tdata,
  // [1:0] command
  input  wire [CMD_W-1:0]        in_tuser,
  output logic                   out_tvalid,
  input  wire                    out_tready,
  // [9:0] bin_ray, rest zero
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // [0] bin_valid
  output logic                   out_tuser,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [TOL_W-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    ST_SWEEP, ST_IDLE, ST_CTR, ST_RUN, ST_DRAIN, ST_RD, ST_RDW, ST_RESP
  } state_t;

  localparam bin_t             LAST_BIN     = BIN_W'(NUM_BINS - 1);
  localparam logic [IDX_W-1:0] NUM_BINS_IDX = IDX_W'(NUM_BINS);

  state_t               state_r, state_nxt;
  logic [TOL_W-1:0]     tol_r;
  logic [EPOCH_W-1:0]   epoch_r, epoch_nxt;
  logic                 pend_r, pend_nxt;
  bin_t                 sweep_r, sweep_nxt;
  logic [RAY_W-1:0]     ray_r, ray_nxt;
  az_t                  azm_r, azm_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  bin_t                 down_r, down_nxt;
  bin_t                 up_r, up_nxt;
  logic [TOL_W-1:0]     k_r, k_nxt;
  logic                 dir_r, dir_nxt;
  logic                 res_v_r, res_v_nxt;
  logic [RAY_W-1:0]     res_ray_r, res_ray_nxt;
  logic                 out_v_r, out_v_nxt;
  logic                 out_u_r, out_u_nxt;
  logic [RAY_W-1:0]     out_ray_r, out_ray_nxt;
  bin_probe_t           s1_r, s1_nxt;

  logic                 in_acc;
  cmd_t                 in_cmd;
  logic [AZ_W+1:0]      round_sum;
  bin_t                 rounded;
  bin_t                 centre;
  bin_t                 bin_sel;
  bin_word_t            new_word;
  bin_word_t            rd_word;
  logic                 ram_we;
  bin_t                 ram_waddr;
  bin_word_t            ram_wdata;
  logic                 ram_re;
  bin_t                 ram_raddr;
  logic                 dist_busy;
  bin_wr_t              dist_wr;
  logic                 hit;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_cmd     = cmd_t'(in_tuser);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tuser  = out_u_r;
  assign out_tdata  = OUT_DATA_W'(out_ray_r);

  // round to the nearest bin centre, the top half-bin wraps to bin 0
  assign round_sum = (AZ_W+2)'(azm_r) + (AZ_W+2)'(HALF_STEP);
  assign rounded   = BIN_W'(round_sum >> FRAC_BITS);
  assign centre    = (rounded == BIN_W'(NUM_BINS)) ? '0 : rounded;
  assign bin_sel   = dir_r ? up_r : down_r;

  assign new_word = '{filled: 1'b1, epoch: epoch_r, az: azm_r, ray: ray_r};
  assign hit      = rd_word.filled && (rd_word.epoch == epoch_r) && (idx_r < NUM_BINS_IDX);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dist_wr.bin;
    ram_wdata = new_word;
    if (state_r == ST_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_r;
      ram_wdata = '0;
    end else if (state_r == ST_CTR) begin
      ram_we    = 1'b1;
      ram_waddr = centre;
    end else if (dist_wr.en) begin
      ram_we    = 1'b1;
    end
  end

  assign ram_re    = (state_r == ST_RUN) || (state_r == ST_RD);
  assign ram_raddr = (state_r == ST_RUN) ? bin_sel : BIN_W'(idx_r);

  always_comb begin
    state_nxt   = state_r;
    epoch_nxt   = epoch_r;
    pend_nxt    = pend_r;
    sweep_nxt   = sweep_r;
    ray_nxt     = ray_r;
    azm_nxt     = azm_r;
    idx_nxt     = idx_r;
    down_nxt    = down_r;
    up_nxt      = up_r;
    k_nxt       = k_r;
    dir_nxt     = dir_r;
    res_v_nxt   = res_v_r;
    res_ray_nxt = res_ray_r;
    out_v_nxt   = out_v_r && !out_tready;
    out_u_nxt   = out_u_r;
    out_ray_nxt = out_ray_r;
    s1_nxt      = '{vld: 1'b0, bin: bin_sel};

    unique case (state_r)
      ST_SWEEP: begin
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == LAST_BIN) begin
          sweep_nxt = '0;
          state_nxt = pend_r ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          ray_nxt     = in_tdata[RAY_W-1:0];
          azm_nxt     = az_reduce(in_tdata[RAY_W +: AZ_W]);
          idx_nxt     = in_tdata[RAY_W+AZ_W +: IDX_W];
          res_v_nxt   = 1'b0;
          res_ray_nxt = '0;
          case (in_cmd)
            CMD_CLEAR: begin
              // a new epoch empties the table; a wrapped epoch needs a sweep
              epoch_nxt = epoch_r + 1'b1;
              if (epoch_nxt == '0) begin
                pend_nxt  = 1'b1;
                state_nxt = ST_SWEEP;
              end else begin
                state_nxt = ST_RESP;
              end
            end
            CMD_ADD:  state_nxt = ST_CTR;
            CMD_READ: state_nxt = ST_RD;
            default:  state_nxt = ST_RESP;
          endcase
        end
      end
      ST_CTR: begin
        down_nxt  = (centre == '0) ? LAST_BIN : centre - 1'b1;
        up_nxt    = (centre == LAST_BIN) ? '0 : centre + 1'b1;
        k_nxt     = TOL_W'(1);
        dir_nxt   = 1'b0;
        state_nxt = (tol_r == '0) ? ST_DRAIN : ST_RUN;
      end
      ST_RUN: begin
        s1_nxt.vld = 1'b1;
        if (!dir_r) begin
          dir_nxt  = 1'b1;
          down_nxt = (down_r == '0) ? LAST_BIN : down_r - 1'b1;
        end else begin
          dir_nxt = 1'b0;
          up_nxt  = (up_r == LAST_BIN) ? '0 : up_r + 1'b1;
          k_nxt   = k_r + 1'b1;
          if (k_r == tol_r) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!dist_busy) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RD: begin
        state_nxt = ST_RDW;
      end
      ST_RDW: begin
        res_v_nxt   = hit;
        res_ray_nxt = hit ? rd_word.ray : '0;
        state_nxt   = ST_RESP;
      end
      ST_RESP: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt   = 1'b1;
          out_u_nxt   = res_v_r;
          out_ray_nxt = res_ray_r;
          pend_nxt    = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      tol_r   <= TOL_W'(1);
      epoch_r <= '0;
      pend_r  <= 1'b0;
      sweep_r <= '0;
      out_v_r <= 1'b0;
      s1_r    <= '0;
    end else begin
      state_r <= state_nxt;
      epoch_r <= epoch_nxt;
      pend_r  <= pend_nxt;
      sweep_r <= sweep_nxt;
      out_v_r <= out_v_nxt;
      s1_r    <= s1_nxt;
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_data;
      end
    end
    ray_r     <= ray_nxt;
    azm_r     <= azm_nxt;
    idx_r     <= idx_nxt;
    down_r    <= down_nxt;
    up_r      <= up_nxt;
    k_r       <= k_nxt;
    dir_r     <= dir_nxt;
    res_v_r   <= res_v_nxt;
    res_ray_r <= res_ray_nxt;
    out_u_r   <= out_u_nxt;
    out_ray_r <= out_ray_nxt;
  end

  abnr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_word)
  );

  abnr_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1      (s1_r),
    .rd_word (rd_word),
    .new_az  (azm_r),
    .epoch   (epoch_r),
    .busy    (dist_busy),
    .wr      (dist_wr)
  );

  // compare pipe must be empty whenever a new item can enter
  `ABNR_ASSERT_IMP(a_idle_pipe_empty, clk, rst_n, in_tready, !dist_busy,
                   "item taken with compare pipe busy")
  // compare write-back never competes with centre or sweep writes
  `ABNR_ASSERT_IMP(a_wr_no_clash, clk, rst_n, dist_wr.en,
                   (state_r == ST_RUN) || (state_r == ST_DRAIN),
                   "write-back outside add run")
  // every table write stays inside the circle
  `ABNR_ASSERT_IMP(a_wr_in_range, clk, rst_n, ram_we, ram_waddr <= LAST_BIN,
                   "table write beyond last bin")
  // an accepted item drops in_tready in the cycle after the accept
  `ABNR_ASSERT_NXT(a_busy_after_acc, clk, rst_n, in_acc, !in_tready,
                   "ready straight after accept")

endmodule

`default_nettype wire
